// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked with synchronous reset disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent in this cycle implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/etl_pkg.sv =====
// ----------------------------------------------------------------------------
// etl_pkg
// types and constants shared by the expression token lexer modules
// ----------------------------------------------------------------------------
package etl_pkg;

   typedef enum logic [2:0] {
      KIND_EOF   = 3'd0,
      KIND_CHAR  = 3'd1,
      KIND_IDENT = 3'd2,
      KIND_INT   = 3'd3,
      KIND_SHL   = 3'd4,
      KIND_SHR   = 3'd5,
      KIND_POW   = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_ZERO,
      MODE_NUM,
      MODE_SKIP,
      MODE_LT,
      MODE_GT,
      MODE_STAR
   } mode_type;

   typedef enum logic [1:0] {
      RADIX_BIN,
      RADIX_OCT,
      RADIX_DEC,
      RADIX_HEX
   } radix_type;

   localparam int ERR_PREFIX   = 0;
   localparam int ERR_DIGIT    = 1;
   localparam int ERR_OVERFLOW = 2;
   localparam int ERR_ANGLE    = 3;

   localparam int DATA_BITS = 144;

   typedef struct packed {
      logic [2:0]  token_kind;
      logic [7:0]  char_code;
      logic [63:0] int_value;
      logic [3:0]  error_flags;
      logic [31:0] start_pos;
      logic [31:0] end_pos;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic [4:0] radix_value(input radix_type r);
      logic [4:0] v;
      case (r)
         RADIX_BIN: v = 5'd2;
         RADIX_OCT: v = 5'd8;
         RADIX_DEC: v = 5'd10;
         RADIX_HEX: v = 5'd16;
         default:   v = 5'd10;
      endcase
      return v;
   endfunction

endpackage

// ===== design/etl_core.sv =====
// ----------------------------------------------------------------------------
// etl_core
// lexer state and one-byte step logic, up to two tokens per byte
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module etl_core #(
   parameter int POSITION_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_valid,
   input  logic [7:0]         ch,
   output etl_pkg::push_type  push
);
   import etl_pkg::*;

   localparam int RepBits = (POSITION_BITS < 32) ? POSITION_BITS : 32;

   mode_type                   mode_ff, mode_in;
   radix_type                  radix_ff, radix_in;
   logic [63:0]                accum_ff, accum_in;
   logic [3:0]                 err_ff, err_in;
   logic [POSITION_BITS-1:0]   start_ff, start_in;
   logic [POSITION_BITS-1:0]   position_ff;
   logic [POSITION_BITS-1:0]   next_pos;

   logic [3:0]                 digit;
   logic                       digit_bad;
   logic [3:0]                 digit_eff;
   logic [67:0]                scaled;
   logic [67:0]                sum;
   logic                       overflow;

   logic                       consumed;
   logic                       pend_emit, idle_emit;
   result_type                 pend_res, idle_res;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_dec(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_hexdig(input logic [7:0] c);
      return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [3:0] v;
      if (is_dec(c)) begin
         v = 4'(c - "0");
      end else if (c >= "a" && c <= "f") begin
         v = 4'(c - "a" + 8'd10);
      end else if (c >= "A" && c <= "F") begin
         v = 4'(c - "A" + 8'd10);
      end else begin
         v = 4'd0;
      end
      return v;
   endfunction

   function automatic logic [31:0] rep_pos(input logic [POSITION_BITS-1:0] p);
      return 32'(p[RepBits-1:0]);
   endfunction

   function automatic result_type make_res(input kind_type k, input logic [7:0] code,
                                           input logic [63:0] v, input logic [3:0] e,
                                           input logic [POSITION_BITS-1:0] s,
                                           input logic [POSITION_BITS-1:0] t);
      result_type r;
      r.token_kind  = k;
      r.char_code   = code;
      r.int_value   = v;
      r.error_flags = e;
      r.start_pos   = rep_pos(s);
      r.end_pos     = rep_pos(t);
      r.last        = 1'b1;
      return r;
   endfunction

   assign next_pos = position_ff + 1'b1;

   // digit accumulate with overflow detect
   assign digit     = hex_val(ch);
   assign digit_bad = 5'(digit) >= radix_value(radix_ff);
   assign digit_eff = digit_bad ? 4'd0 : digit;

   always_comb begin
      case (radix_ff)
         RADIX_BIN: scaled = {4'd0, accum_ff} << 1;
         RADIX_OCT: scaled = {4'd0, accum_ff} << 3;
         RADIX_DEC: scaled = ({4'd0, accum_ff} << 3) + ({4'd0, accum_ff} << 1);
         RADIX_HEX: scaled = {4'd0, accum_ff} << 4;
         default:   scaled = {4'd0, accum_ff};
      endcase
   end

   assign sum      = scaled + 68'(digit_eff);
   assign overflow = |sum[67:64];

   always_comb begin
      mode_in   = mode_ff;
      radix_in  = radix_ff;
      accum_in  = accum_ff;
      err_in    = err_ff;
      start_in  = start_ff;
      consumed  = 1'b0;
      pend_emit = 1'b0;
      idle_emit = 1'b0;
      pend_res  = make_res(KIND_EOF, 8'd0, 64'd0, 4'd0, position_ff, next_pos);
      idle_res  = make_res(KIND_EOF, 8'd0, 64'd0, 4'd0, position_ff, next_pos);

      // pending token
      case (mode_ff)
         MODE_IDLE: begin
            consumed = 1'b0;
         end
         MODE_IDENT: begin
            if (is_letter(ch) || is_dec(ch) || ch == "_") begin
               consumed = 1'b1;
            end else begin
               pend_emit = 1'b1;
               pend_res  = make_res(KIND_IDENT, 8'd0, 64'd0, 4'd0, start_ff, position_ff);
               mode_in   = MODE_IDLE;
            end
         end
         MODE_ZERO: begin
            consumed = 1'b1;
            mode_in  = MODE_NUM;
            if (ch == "b" || ch == "B") begin
               radix_in = RADIX_BIN;
            end else if (ch == "x" || ch == "X") begin
               radix_in = RADIX_HEX;
            end else if (ch >= "0" && ch <= "7") begin
               radix_in = RADIX_OCT;
               accum_in = 64'(digit);
            end else if (is_letter(ch) || is_dec(ch)) begin
               err_in[ERR_PREFIX] = 1'b1;
               radix_in = RADIX_DEC;
            end else begin
               consumed  = 1'b0;
               mode_in   = MODE_IDLE;
               pend_emit = 1'b1;
               pend_res  = make_res(KIND_INT, 8'd0, 64'd0, err_ff, start_ff, position_ff);
            end
         end
         MODE_NUM: begin
            if (is_hexdig(ch)) begin
               consumed = 1'b1;
               if (digit_bad) begin
                  err_in[ERR_DIGIT] = 1'b1;
               end
               if (overflow) begin
                  err_in[ERR_OVERFLOW] = 1'b1;
                  accum_in = 64'd0;
                  mode_in  = MODE_SKIP;
               end else begin
                  accum_in = sum[63:0];
               end
            end else begin
               pend_emit = 1'b1;
               pend_res  = make_res(KIND_INT, 8'd0, accum_ff, err_ff, start_ff, position_ff);
               mode_in   = MODE_IDLE;
            end
         end
         MODE_SKIP: begin
            if (is_hexdig(ch)) begin
               consumed = 1'b1;
            end else begin
               pend_emit = 1'b1;
               pend_res  = make_res(KIND_INT, 8'd0, 64'd0, err_ff, start_ff, position_ff);
               mode_in   = MODE_IDLE;
            end
         end
         MODE_LT, MODE_GT: begin
            mode_in   = MODE_IDLE;
            pend_emit = 1'b1;
            if (ch == ((mode_ff == MODE_LT) ? "<" : ">")) begin
               consumed = 1'b1;
               pend_res = make_res((mode_ff == MODE_LT) ? KIND_SHL : KIND_SHR, 8'd0, 64'd0,
                                   4'd0, start_ff, next_pos);
            end else begin
               pend_res = make_res((mode_ff == MODE_LT) ? KIND_SHL : KIND_SHR, 8'd0, 64'd0,
                                   4'(1 << ERR_ANGLE), start_ff, position_ff);
            end
         end
         MODE_STAR: begin
            mode_in   = MODE_IDLE;
            pend_emit = 1'b1;
            if (ch == "*") begin
               consumed = 1'b1;
               pend_res = make_res(KIND_POW, 8'd0, 64'd0, 4'd0, start_ff, next_pos);
            end else begin
               pend_res = make_res(KIND_CHAR, "*", 64'd0, 4'd0, start_ff, position_ff);
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      // byte starts a fresh token
      if (!consumed) begin
         if (ch == " " || ch == 8'h09 || ch == 8'h0a || ch == 8'h0d || ch == 8'h0b) begin
            idle_emit = 1'b0;
         end else if (is_letter(ch) || ch == "_") begin
            start_in = position_ff;
            mode_in  = MODE_IDENT;
         end else if (ch == "0") begin
            start_in = position_ff;
            accum_in = 64'd0;
            err_in   = 4'd0;
            radix_in = RADIX_DEC;
            mode_in  = MODE_ZERO;
         end else if (is_dec(ch)) begin
            start_in = position_ff;
            accum_in = 64'(digit);
            err_in   = 4'd0;
            radix_in = RADIX_DEC;
            mode_in  = MODE_NUM;
         end else if (ch == "<") begin
            start_in = position_ff;
            mode_in  = MODE_LT;
         end else if (ch == ">") begin
            start_in = position_ff;
            mode_in  = MODE_GT;
         end else if (ch == "*") begin
            start_in = position_ff;
            mode_in  = MODE_STAR;
         end else if (ch == 8'd0) begin
            idle_emit = 1'b1;
            idle_res  = make_res(KIND_EOF, 8'd0, 64'd0, 4'd0, position_ff, next_pos);
         end else begin
            idle_emit = 1'b1;
            idle_res  = make_res(KIND_CHAR, ch, 64'd0, 4'd0, position_ff, next_pos);
         end
      end
   end

   always_comb begin
      push.count  = step_valid ? (2'(pend_emit) + 2'(idle_emit)) : 2'd0;
      push.first  = pend_emit ? pend_res : idle_res;
      push.second = idle_res;
      push.first.last = !(pend_emit && idle_emit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         radix_ff    <= RADIX_DEC;
         accum_ff    <= 64'd0;
         err_ff      <= 4'd0;
         start_ff    <= '0;
         position_ff <= '0;
      end else if (step_valid) begin
         mode_ff     <= mode_in;
         radix_ff    <= radix_in;
         accum_ff    <= accum_in;
         err_ff      <= err_in;
         start_ff    <= start_in;
         position_ff <= next_pos;
      end
   end

   `ASSERT_IMPLY(a_two_ends_fresh, clock, reset, push.count == 2'd2,
      push.second.token_kind == KIND_EOF || push.second.token_kind == KIND_CHAR,
      "second token of a byte is not eof or single char")
   `ASSERT_IMPLY(a_push_needs_step, clock, reset, push.count != 2'd0, step_valid,
      "token emitted without a byte")
   `ASSERT_IMPLY(a_skip_has_overflow, clock, reset, mode_ff == MODE_SKIP,
      err_ff[ERR_OVERFLOW], "skip mode without overflow flag")

endmodule

// ===== design/etl_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// etl_rsp_queue
// four-entry token queue, up to two pushes and one pop per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module etl_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  etl_pkg::push_type    push,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output etl_pkg::result_type  head
);
   import etl_pkg::*;

   localparam int Depth   = 4;
   localparam int PtrBits = 2;

   result_type           entry_ff [Depth];
   logic [PtrBits-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PtrBits:0]     count_ff, count_in;
   logic                 pop;

   assign room      = count_ff <= 3'(Depth - 2);
   assign rsp_valid = count_ff != '0;
   assign head      = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign count_in  = count_ff + 3'(push.count) - 3'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + 1'b1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PtrBits'(push.count);
         rd_ptr_ff <= rd_ptr_ff + PtrBits'(pop);
         count_ff  <= count_in;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= 3'(Depth),
      "queue count beyond depth")
   `ASSERT_IMPLY(a_push_fits, clock, reset, push.count != 2'd0, room,
      "push into queue without room")
   `ASSERT_IMPLY(a_pair_last, clock, reset, push.count == 2'd2,
      !push.first.last && push.second.last, "last marker wrong on token pair")

endmodule

// ===== design/expression_token_lexer.sv =====
// ----------------------------------------------------------------------------
// expression_token_lexer
// streaming lexer: one character byte in, tokens with positions out
// ----------------------------------------------------------------------------
//  channel | dir | transaction
//  req     | in  | one character byte (tdata[7:0])
//  rsp     | out | one token, kind on tuser, tlast on the final token of a byte
//
//  one byte per cycle while the queue has room; each byte yields zero, one or two tokens
//  a byte is held in the input register, then its tokens enter the queue
//  rsp_tvalid follows the queue count, so a token is offered once it is written into the queue
//  the four-entry token queue sets the stall: a byte waits while fewer than two slots are free
//  reset is synchronous and returns the lexer to idle at position zero
// ----------------------------------------------------------------------------
module expression_token_lexer #(
   parameter int POSITION_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // ch
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // char_code, int_value, error_flags, start_pos, end_pos, pad
   output logic [etl_pkg::DATA_BITS-1:0] rsp_tdata,
   output logic [2:0]                    rsp_tuser,  // token_kind
   output logic                          rsp_tlast
);
   import etl_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        room;
   logic        advance;
   push_type    push;
   result_type  head;

   assign advance    = in_valid_ff && room;
   assign req_tready = !in_valid_ff || room;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   etl_core #(
      .POSITION_BITS(POSITION_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .ch         (in_byte_ff),
      .push       (push)
   );

   etl_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .head      (head)
   );

   assign rsp_tdata = {4'd0, head.end_pos, head.start_pos, head.error_flags,
                       head.int_value, head.char_code};
   assign rsp_tuser = head.token_kind;
   assign rsp_tlast = head.last;

endmodule

// ===== sim/tb_expression_token_lexer.sv =====
// ----------------------------------------------------------------------------
// tb_expression_token_lexer
// feeds character streams to the lexer through the req channel and checks
// every rsp token against a cycle-free software lexer kept in this file;
// directed corner cases first, then random token streams with random gaps
// on the req side and random back-pressure on the rsp side
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_expression_token_lexer;
   import etl_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = 8'h00;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_BITS-1:0] rsp_tdata;
   logic [2:0]           rsp_tuser;
   logic                 rsp_tlast;

   expression_token_lexer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // lexer state mirrored in the testbench
   mode_type    lex_mode  = MODE_IDLE;
   logic [4:0]  lex_radix = 5'd10;
   logic [63:0] lex_acc   = '0;
   logic [3:0]  lex_err   = '0;
   logic [31:0] lex_start = '0;
   logic [31:0] lex_pos   = '0;

   result_type  byte_toks[$];
   result_type  token_q[$];

   int  errors = 0;
   int  sent_nonblank = 0;
   bit  quiet = 1'b0;
   int  stall_left = 0;

   function automatic bit is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_dec(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_hexdig(input logic [7:0] c);
      return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h0B;
   endfunction

   function automatic logic [63:0] digit_value(input logic [7:0] c);
      if (is_dec(c)) return 64'(c - "0");
      if (c >= "a" && c <= "f") return 64'(c - "a" + 10);
      if (c >= "A" && c <= "F") return 64'(c - "A" + 10);
      return 64'd0;
   endfunction

   function automatic void add_token(input kind_type k, input logic [7:0] code,
                                     input logic [63:0] v, input logic [3:0] e,
                                     input logic [31:0] s, input logic [31:0] f);
      result_type t;
      t.token_kind  = k;
      t.char_code   = code;
      t.int_value   = v;
      t.error_flags = e;
      t.start_pos   = s;
      t.end_pos     = f;
      t.last        = 1'b0;
      byte_toks.push_back(t);
   endfunction

   function automatic void take_digit(input logic [7:0] c);
      logic [63:0] d;
      d = digit_value(c);
      if (d >= 64'(lex_radix)) begin
         lex_err[ERR_DIGIT] = 1'b1;
         d = 64'd0;
      end
      if (lex_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'(lex_radix)) begin
         lex_err[ERR_OVERFLOW] = 1'b1;
         lex_acc  = 64'd0;
         lex_mode = MODE_SKIP;
      end else begin
         lex_acc = lex_acc * 64'(lex_radix) + d;
      end
   endfunction

   function automatic void begin_number();
      lex_start = lex_pos;
      lex_acc   = 64'd0;
      lex_err   = 4'd0;
      lex_radix = 5'd10;
   endfunction

   // byte seen with no token pending
   function automatic void lex_fresh(input logic [7:0] c);
      if (is_blank(c)) return;
      if (is_letter(c) || c == "_") begin
         lex_start = lex_pos;
         lex_mode  = MODE_IDENT;
      end else if (c == "0") begin
         begin_number();
         lex_mode = MODE_ZERO;
      end else if (is_dec(c)) begin
         begin_number();
         lex_mode = MODE_NUM;
         lex_acc  = 64'(c - "0");
      end else if (c == "<") begin
         lex_start = lex_pos;
         lex_mode  = MODE_LT;
      end else if (c == ">") begin
         lex_start = lex_pos;
         lex_mode  = MODE_GT;
      end else if (c == "*") begin
         lex_start = lex_pos;
         lex_mode  = MODE_STAR;
      end else if (c == 8'h00) begin
         add_token(KIND_EOF, 8'h00, 64'd0, 4'd0, lex_pos, lex_pos + 32'd1);
      end else begin
         add_token(KIND_CHAR, c, 64'd0, 4'd0, lex_pos, lex_pos + 32'd1);
      end
   endfunction

   // returns 1 when the pending token swallows the byte
   function automatic bit lex_continue(input logic [7:0] c);
      logic [7:0] want;
      kind_type   k;
      case (lex_mode)
         MODE_IDENT: begin
            if (is_letter(c) || is_dec(c) || c == "_") return 1'b1;
            add_token(KIND_IDENT, 8'h00, 64'd0, 4'd0, lex_start, lex_pos);
         end
         MODE_ZERO: begin
            if (c == "b" || c == "B") begin
               lex_radix = 5'd2;
               lex_mode  = MODE_NUM;
               return 1'b1;
            end
            if (c == "x" || c == "X") begin
               lex_radix = 5'd16;
               lex_mode  = MODE_NUM;
               return 1'b1;
            end
            if (c >= "0" && c <= "7") begin
               lex_radix = 5'd8;
               lex_mode  = MODE_NUM;
               take_digit(c);
               return 1'b1;
            end
            if (is_letter(c) || is_dec(c)) begin
               lex_err[ERR_PREFIX] = 1'b1;
               lex_radix = 5'd10;
               lex_mode  = MODE_NUM;
               return 1'b1;
            end
            add_token(KIND_INT, 8'h00, 64'd0, lex_err, lex_start, lex_pos);
         end
         MODE_NUM: begin
            if (is_hexdig(c)) begin
               take_digit(c);
               return 1'b1;
            end
            add_token(KIND_INT, 8'h00, lex_acc, lex_err, lex_start, lex_pos);
         end
         MODE_SKIP: begin
            if (is_hexdig(c)) return 1'b1;
            add_token(KIND_INT, 8'h00, 64'd0, lex_err, lex_start, lex_pos);
         end
         MODE_LT, MODE_GT: begin
            want = (lex_mode == MODE_LT) ? "<" : ">";
            k    = (lex_mode == MODE_LT) ? KIND_SHL : KIND_SHR;
            lex_mode = MODE_IDLE;
            if (c == want) begin
               add_token(k, 8'h00, 64'd0, 4'd0, lex_start, lex_pos + 32'd1);
               return 1'b1;
            end
            add_token(k, 8'h00, 64'd0, 4'd1 << ERR_ANGLE, lex_start, lex_pos);
            return 1'b0;
         end
         MODE_STAR: begin
            lex_mode = MODE_IDLE;
            if (c == "*") begin
               add_token(KIND_POW, 8'h00, 64'd0, 4'd0, lex_start, lex_pos + 32'd1);
               return 1'b1;
            end
            add_token(KIND_CHAR, "*", 64'd0, 4'd0, lex_start, lex_pos);
            return 1'b0;
         end
         default: ;
      endcase
      lex_mode = MODE_IDLE;
      return 1'b0;
   endfunction

   function automatic void lex_byte(input logic [7:0] c);
      result_type t;
      int n;
      byte_toks.delete();
      if (lex_mode == MODE_IDLE || !lex_continue(c)) lex_fresh(c);
      n = byte_toks.size();
      for (int i = 0; i < n; i++) begin
         t = byte_toks[i];
         t.last = (i == n - 1);
         token_q.push_back(t);
      end
      lex_pos = lex_pos + 32'd1;
   endfunction

   function automatic int gap_len();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int stall_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // rsp side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
         stall_left = stall_len() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // token checker
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got.token_kind  = rsp_tuser;
         got.char_code   = rsp_tdata[7:0];
         got.int_value   = rsp_tdata[71:8];
         got.error_flags = rsp_tdata[75:72];
         got.start_pos   = rsp_tdata[107:76];
         got.end_pos     = rsp_tdata[139:108];
         got.last        = rsp_tlast;
         if (token_q.size() == 0) begin
            if (errors < 10)
               $display("unexpected token: kind %0d char %02h val %016h err %h %s %0d end %0d",
                        got.token_kind, got.char_code, got.int_value, got.error_flags,
                        "start", got.start_pos, got.end_pos);
            errors++;
         end else begin
            want = token_q.pop_front();
            if (got.token_kind !== want.token_kind || got.char_code !== want.char_code ||
                got.int_value !== want.int_value || got.error_flags !== want.error_flags ||
                got.start_pos !== want.start_pos || got.end_pos !== want.end_pos ||
                got.last !== want.last) begin
               if (errors < 10) begin
                  $display("token mismatch at %0t", $realtime);
                  $display("  expected kind %0d char %02h val %016h err %h",
                           want.token_kind, want.char_code, want.int_value,
                           want.error_flags);
                  $display("           start %0d end %0d last %b",
                           want.start_pos, want.end_pos, want.last);
                  $display("  actual   kind %0d char %02h val %016h err %h",
                           got.token_kind, got.char_code, got.int_value,
                           got.error_flags);
                  $display("           start %0d end %0d last %b",
                           got.start_pos, got.end_pos, got.last);
               end
               errors++;
            end
         end
      end
   end

   // one req transaction; valid stays high when the next byte follows at once
   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (req_tready !== 1'b1);
      lex_byte(c);
      if (!is_blank(c)) sent_nonblank++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   function automatic logic [7:0] pick_from(input string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   function automatic logic [7:0] hex_digit(input int v, input bit up);
      if (v < 10) return 8'("0" + v);
      return up ? 8'("A" + v - 10) : 8'("a" + v - 10);
   endfunction

   task automatic send_ident();
      int len;
      send_char(pick_from("_abcxyzQRSTbB"));
      len = $urandom_range(0, 7);
      repeat (len)
         send_char(pick_from(
            "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789"));
   endtask

   task automatic send_number();
      int sel;
      int len;
      bit up;
      sel = $urandom_range(0, 10);
      up  = $urandom_range(0, 1);
      case (sel)
         0, 1: begin
            send_char(hex_digit($urandom_range(1, 9), 0));
            len = $urandom_range(0, 6);
            repeat (len) send_char(hex_digit($urandom_range(0, 9), 0));
         end
         2: begin
            send_char(hex_digit($urandom_range(1, 9), 0));
            len = $urandom_range(17, 22);
            repeat (len) send_char(hex_digit($urandom_range(0, 9), 0));
         end
         3, 4: begin
            send_char("0");
            send_char(up ? "X" : "x");
            len = (sel == 3) ? $urandom_range(0, 16) : $urandom_range(17, 20);
            repeat (len) send_char(hex_digit($urandom_range(0, 15), $urandom_range(0, 1)));
         end
         5: begin
            send_char("0");
            send_char(up ? "B" : "b");
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(62, 68) : $urandom_range(0, 10);
            repeat (len) begin
               if ($urandom_range(0, 7) == 0)
                  send_char(hex_digit($urandom_range(0, 15), up));
               else
                  send_char(hex_digit($urandom_range(0, 1), up));
            end
         end
         6: begin
            send_char("0");
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(21, 24) : $urandom_range(1, 8);
            send_char(hex_digit($urandom_range(0, 7), 0));
            repeat (len - 1) begin
               if ($urandom_range(0, 7) == 0)
                  send_char(hex_digit($urandom_range(8, 15), up));
               else
                  send_char(hex_digit($urandom_range(0, 7), 0));
            end
         end
         7: send_char("0");
         8: begin
            send_char("0");
            send_char(pick_from("89acdefghkoqzACDEGHOQZ"));
            len = $urandom_range(0, 4);
            repeat (len) send_char(hex_digit($urandom_range(0, 15), up));
         end
         9: begin
            send_char(hex_digit($urandom_range(1, 9), 0));
            len = $urandom_range(1, 5);
            repeat (len) send_char(hex_digit($urandom_range(0, 15), up));
         end
         default: begin
            case ($urandom_range(0, 3))
               0: send_text("18446744073709551615");
               1: send_text("18446744073709551616");
               2: send_text("0xFFFFFFFFFFFFFFFF");
               default: send_text("0x10000000000000000");
            endcase
         end
      endcase
   endtask

   task automatic send_separator();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) begin
         send_char(pick_from(" \t\n\r"));
         if (r == 0) send_char(8'h0B);
      end else if (r < 6) begin
         send_char(pick_from("+-/%(),;=&|^~!"));
      end else if (r == 6) begin
         send_char(pick_from("<>*"));
      end else if (r == 7) begin
         send_char(pick_from("ghkmnpqrstuvwyzG_"));
      end else if (r == 8) begin
         send_char(8'h00);
      end
   endtask

   task automatic test_basic_tokens();
      send_text("_z9");
      send_char(8'h80);
      send_text("0 09 0b2,0x<<>a**\t*");
      send_char(8'h0B);
      send_char(8'hFF);
      send_char(8'h00);
   endtask

   task automatic test_number_literals(input int count);
      int goal;
      goal = sent_nonblank + count;
      while (sent_nonblank < goal) begin
         send_number();
         send_separator();
      end
   endtask

   task automatic test_mixed_stream(input int count);
      int goal;
      int pieces;
      int len;
      goal = sent_nonblank + count;
      pieces = 0;
      while (sent_nonblank < goal) begin
         if (pieces % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
         pieces++;
         case ($urandom_range(0, 11))
            0, 1, 2: send_ident();
            3, 4:    send_number();
            5, 6: begin
               case ($urandom_range(0, 7))
                  0: send_text("<<");
                  1: send_text(">>");
                  2: send_text("**");
                  3: send_text("<>");
                  4: send_text("<<<");
                  5: send_text("***");
                  default: send_char(pick_from("<>*"));
               endcase
            end
            7: send_char(pick_from("+-/%(),;=&|^~!.[]{}"));
            8: begin
               len = $urandom_range(1, 4);
               repeat (len) send_char(pick_from(" \t\n\r"));
            end
            9:  send_char(8'($urandom_range(1, 255)));
            10: send_char(8'h00);
            default: begin
               len = $urandom_range(1, 6);
               repeat (len) send_char(pick_from("0xXbB<>*_a9f8 "));
            end
         endcase
         if ($urandom_range(0, 1) == 0) send_separator();
      end
      quiet = 1'b0;
   endtask

   initial begin
      int wait_cycles;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_basic_tokens();
      test_number_literals(300);
      test_mixed_stream(650);
      req_tvalid <= 1'b0;
      wait_cycles = 0;
      while (token_q.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (token_q.size() != 0) begin
         if (errors < 10) $display("%0d expected tokens never arrived", token_q.size());
         errors++;
      end
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("[expression_token_lexer] OK");
      end else begin
         $display("[expression_token_lexer] ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[expression_token_lexer] ERROR");
      $finish;
   end

endmodule
